@@ hdl/multi_line_job_dispatcher_core_macros.svh @@
// Assertion macros used by the dispatcher checker.
`ifndef MULTI_LINE_JOB_DISPATCHER_CORE_MACROS_SVH
`define MULTI_LINE_JOB_DISPATCHER_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define MLJD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define MLJD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mljd_pkg.sv @@
// Shared types, constants and control store of the job dispatcher.
package mljd_pkg;

    // Register reset values and arithmetic constants
    localparam logic [5:0]  RESET_WINDOW_COUNT  = 6'd1;
    localparam logic [4:0]  RESET_LINE_CAPACITY = 5'd1;
    localparam logic [10:0] RESET_OPEN          = 11'(8 * 60);
    localparam logic [10:0] RESET_CLOSE         = 11'(17 * 60);
    localparam logic [15:0] TIME_MAX            = 16'hFFFF;
    localparam logic [15:0] MIN_PER_HOUR        = 16'd60;
    // floor(x / 60) == (x * DIV60_MUL) >> DIV60_SHIFT for every 16-bit x
    localparam logic [31:0] DIV60_MUL           = 32'd34953;
    localparam int          DIV60_SHIFT         = 21;
    localparam int          APB_AW              = 4;

    typedef enum logic [1:0] {
        REG_WINDOW_COUNT,
        REG_LINE_CAPACITY,
        REG_OPEN_MINUTE,
        REG_CLOSE_MINUTE
    } reg_index_t;

    typedef struct packed {
        logic [5:0]  window_count;
        logic [4:0]  line_capacity;
        logic [10:0] open_minute;
        logic [10:0] close_minute;
    } cfg_t;

    // Program addresses
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DECIDE,
        ST_FILL_INIT,
        ST_FILL_DIV,
        ST_FILL_DONE,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_HEAD_READ,
        ST_HEAD_UPDATE,
        ST_NF_READ,
        ST_FINISH,
        ST_PRODUCT,
        ST_OUT
    } step_t;

    // Datapath actions
    typedef enum logic [3:0] {
        OP_NOP,
        OP_TAKE,
        OP_CLEAR,
        OP_FILL_INIT,
        OP_DIV_STEP,
        OP_FILL_DONE,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_HEAD_READ,
        OP_HEAD_UPDATE,
        OP_FINISH,
        OP_PRODUCT,
        OP_OUT
    } dp_op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_IN_VALID,
        C_FULL,
        C_DIV_LAST,
        C_SCAN_DONE,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        logic   stay;     // hold the step while the condition is false
        step_t  target;
    } ucode_t;

    typedef struct packed {
        logic full;       // all lines filled, use the earliest-head scan
        logic div_last;   // last quotient bit in progress
        logic scan_done;  // scan pipeline drained
        logic out_free;   // result register can take a beat
    } status_t;

    // Control store
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        unique case (s)
            ST_IDLE:        w = '{OP_TAKE,        C_IN_VALID,  1'b1, ST_CLEAR};
            ST_CLEAR:       w = '{OP_CLEAR,       C_NONE,      1'b0, ST_IDLE};
            ST_DECIDE:      w = '{OP_NOP,         C_FULL,      1'b0, ST_SCAN_INIT};
            ST_FILL_INIT:   w = '{OP_FILL_INIT,   C_NONE,      1'b0, ST_IDLE};
            ST_FILL_DIV:    w = '{OP_DIV_STEP,    C_DIV_LAST,  1'b1, ST_FILL_DONE};
            ST_FILL_DONE:   w = '{OP_FILL_DONE,   C_ALWAYS,    1'b0, ST_NF_READ};
            ST_SCAN_INIT:   w = '{OP_SCAN_INIT,   C_NONE,      1'b0, ST_IDLE};
            ST_SCAN:        w = '{OP_SCAN,        C_SCAN_DONE, 1'b1, ST_HEAD_READ};
            ST_HEAD_READ:   w = '{OP_HEAD_READ,   C_NONE,      1'b0, ST_IDLE};
            ST_HEAD_UPDATE: w = '{OP_HEAD_UPDATE, C_NONE,      1'b0, ST_IDLE};
            ST_NF_READ:     w = '{OP_NOP,         C_NONE,      1'b0, ST_IDLE};
            ST_FINISH:      w = '{OP_FINISH,      C_NONE,      1'b0, ST_IDLE};
            ST_PRODUCT:     w = '{OP_PRODUCT,     C_NONE,      1'b0, ST_IDLE};
            ST_OUT:         w = '{OP_OUT,         C_OUT_FREE,  1'b1, ST_IDLE};
            default:        w = '{OP_NOP,         C_ALWAYS,    1'b0, ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ hdl/mljd_cfg.sv @@
// APB register file holding the dispatcher configuration.
module mljd_cfg
    import mljd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_count  <= RESET_WINDOW_COUNT;
            cfg_reg.line_capacity <= RESET_LINE_CAPACITY;
            cfg_reg.open_minute   <= RESET_OPEN;
            cfg_reg.close_minute  <= RESET_CLOSE;
        end else if (wr_en) begin
            unique case (index)
                REG_WINDOW_COUNT:  cfg_reg.window_count  <= pwdata[5:0];
                REG_LINE_CAPACITY: cfg_reg.line_capacity <= pwdata[4:0];
                REG_OPEN_MINUTE:   cfg_reg.open_minute   <= pwdata[10:0];
                REG_CLOSE_MINUTE:  cfg_reg.close_minute  <= pwdata[10:0];
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        unique case (index)
            REG_WINDOW_COUNT:  prdata = 32'(cfg_reg.window_count);
            REG_LINE_CAPACITY: prdata = 32'(cfg_reg.line_capacity);
            REG_OPEN_MINUTE:   prdata = 32'(cfg_reg.open_minute);
            REG_CLOSE_MINUTE:  prdata = 32'(cfg_reg.close_minute);
        endcase
    end

endmodule

@@ hdl/mljd_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jumps.
module mljd_seq
    import mljd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  status_t stat,
    output ucode_t  uc
);

    step_t step_reg;
    step_t step_next;
    logic  jump;

    // Hold the step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    // Fetch the control word and pick the next step
    always_comb begin
        uc = ucode_rom(step_reg);
        unique case (uc.cond)
            C_NONE:      jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_IN_VALID:  jump = s_valid;
            C_FULL:      jump = stat.full;
            C_DIV_LAST:  jump = stat.div_last;
            C_SCAN_DONE: jump = stat.scan_done;
            C_OUT_FREE:  jump = stat.out_free;
            default:     jump = 1'b1;
        endcase
        priority if (jump) begin
            step_next = uc.target;
        end else if (uc.stay) begin
            step_next = step_reg;
        end else begin
            step_next = step_t'(4'(step_reg) + 4'd1);
        end
    end

endmodule

@@ hdl/mljd_dp.sv @@
// Dispatcher datapath: line stores, fill divider, head scan and result stage.
module mljd_dp
    import mljd_pkg::*;
#(
    parameter int MAX_SERVERS = 32,
    parameter int MAX_LINE    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  ucode_t      uc,
    output status_t     stat,
    input  cfg_t        cfg,
    input  logic        s_valid,
    input  logic [9:0]  s_service_minutes,
    input  logic        s_new_day,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_server_index,
    output logic [15:0] m_start_minute,
    output logic [15:0] m_end_minute,
    output logic [10:0] m_end_hour,
    output logic [5:0]  m_end_min_of_hour,
    output logic        m_refused
);

    localparam int SVW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int LNW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int NW  = $clog2(MAX_SERVERS + 1);
    localparam int MW  = $clog2(MAX_LINE + 1);
    localparam int PW  = NW + MW;
    localparam int LD  = MAX_SERVERS * MAX_LINE;
    localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
    localparam int AW  = $clog2(LD + 1);
    localparam int KW  = (LNW > 1) ? $clog2(LNW) : 1;

    function automatic logic [LAW-1:0] line_addr(input logic [SVW-1:0] s,
                                                 input logic [LNW-1:0] h);
        return LAW'(s) * LAW'(MAX_LINE) + LAW'(h);
    endfunction

    // Job and day registers
    logic [9:0]     svc_reg;
    logic           nd_reg;
    logic [SVW-1:0] srv_reg;
    logic [LNW-1:0] slot_reg;
    logic [AW-1:0]  adm_reg;
    logic [SVW-1:0] fp_reg;
    logic [10:0]    day_open_reg;

    // Fill divider
    logic [AW-1:0]  rem_reg;
    logic [LNW-1:0] q_reg;
    logic [KW-1:0]  k_reg;

    // Scan pipeline
    logic [NW-1:0]  j_reg;
    logic           p1_vld_reg;
    logic [SVW-1:0] p1_idx_reg;
    logic           p2_vld_reg;
    logic [SVW-1:0] p2_idx_reg;
    logic [15:0]    early_reg;
    logic [SVW-1:0] best_reg;

    // Result stage
    logic [15:0]    start_reg;
    logic [15:0]    end_reg;
    logic [31:0]    prod_reg;
    logic           m_valid_reg;

    // Stores
    logic [LNW-1:0]         head_mem [MAX_SERVERS];
    logic [MAX_SERVERS-1:0] head_vld_reg;
    logic [LNW-1:0]         head_rd_reg;
    logic                   head_rv_reg;
    logic [15:0]            nf_mem [MAX_SERVERS];
    logic [MAX_SERVERS-1:0] nf_vld_reg;
    logic [15:0]            nf_rd_reg;
    logic                   nf_rv_reg;
    logic [15:0]            line_mem [LD];
    logic [15:0]            line_rd_reg;

    // Combinational terms
    logic [NW-1:0]  n;
    logic [MW-1:0]  m;
    logic [PW-1:0]  nm;
    logic [PW-1:0]  dsub;
    logic [SVW-1:0] head_ra;
    logic           head_we;
    logic [SVW-1:0] head_wa;
    logic [LNW-1:0] head_wd;
    logic [LNW-1:0] h_eff;
    logic [LNW-1:0] h_fix;
    logic           h_big;
    logic [MW-1:0]  h_inc;
    logic [LAW-1:0] line_ra;
    logic [15:0]    start_val;
    logic [16:0]    sum_val;
    logic [15:0]    end_val;
    logic [NW:0]    fp_inc;
    logic [10:0]    hour_val;
    logic [15:0]    hour_min;
    logic           out_load;
    logic           scan_issue;

    // Clamp the geometry registers into range
    always_comb begin
        priority if (cfg.window_count == 6'd0) begin
            n = NW'(1);
        end else if (7'(cfg.window_count) > 7'(MAX_SERVERS)) begin
            n = NW'(MAX_SERVERS);
        end else begin
            n = NW'(cfg.window_count);
        end
        priority if (cfg.line_capacity == 5'd0) begin
            m = MW'(1);
        end else if (7'(cfg.line_capacity) > 7'(MAX_LINE)) begin
            m = MW'(MAX_LINE);
        end else begin
            m = MW'(cfg.line_capacity);
        end
    end

    assign nm         = PW'(n) * PW'(m);
    assign dsub       = PW'(n) << k_reg;
    assign scan_issue = (uc.op == OP_SCAN) && (j_reg < n);
    assign out_load   = (uc.op == OP_OUT) && (!m_valid_reg || m_ready);

    assign stat.full      = PW'(adm_reg) >= nm;
    assign stat.div_last  = (k_reg == '0);
    assign stat.scan_done = (j_reg >= n) && !p1_vld_reg && !p2_vld_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

    // Head read data, with the wrap of a head beyond the line size
    always_comb begin
        h_eff = head_rv_reg ? head_rd_reg : '0;
        h_big = MW'(h_eff) >= m;
        h_fix = h_big ? '0 : h_eff;
        h_inc = MW'(h_eff) + MW'(1);
    end

    // Head store port selection
    always_comb begin
        head_ra = (uc.op == OP_SCAN) ? j_reg[SVW-1:0] : best_reg;
        head_we = 1'b0;
        head_wa = srv_reg;
        head_wd = '0;
        if (uc.op == OP_SCAN && p1_vld_reg && h_big) begin
            head_we = 1'b1;
            head_wa = p1_idx_reg;
        end else if (uc.op == OP_HEAD_UPDATE) begin
            head_we = 1'b1;
            head_wd = (h_inc >= m) ? '0 : LNW'(h_inc);
        end
    end

    assign line_ra = line_addr(p1_idx_reg, h_fix);

    // Start, end and fill pointer arithmetic
    always_comb begin
        start_val = nf_rv_reg ? nf_rd_reg : 16'(day_open_reg);
        sum_val   = 17'(start_val) + 17'(svc_reg);
        end_val   = sum_val[16] ? TIME_MAX : sum_val[15:0];
        fp_inc    = (NW + 1)'(srv_reg) + (NW + 1)'(1);
        hour_val  = 11'(prod_reg >> DIV60_SHIFT);
        hour_min  = 16'(hour_val) * MIN_PER_HOUR;
    end

    // Head store
    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_wa] <= head_wd;
        end
        head_rd_reg <= head_mem[head_ra];
        head_rv_reg <= head_vld_reg[head_ra];
    end

    // Next-free store
    always_ff @(posedge aclk) begin
        if (uc.op == OP_FINISH) begin
            nf_mem[srv_reg] <= end_val;
        end
        nf_rd_reg <= nf_mem[srv_reg];
        nf_rv_reg <= nf_vld_reg[srv_reg];
    end

    // Line slot store
    always_ff @(posedge aclk) begin
        if (uc.op == OP_FINISH) begin
            line_mem[line_addr(srv_reg, slot_reg)] <= end_val;
        end
        line_rd_reg <= line_mem[line_ra];
    end

    // Control state: day counters, valid bits, scan flags, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adm_reg      <= '0;
            fp_reg       <= '0;
            day_open_reg <= RESET_OPEN;
            head_vld_reg <= '0;
            nf_vld_reg   <= '0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // Clear the day on request
            if (uc.op == OP_CLEAR && nd_reg) begin
                adm_reg      <= '0;
                fp_reg       <= '0;
                day_open_reg <= cfg.open_minute;
                head_vld_reg <= '0;
                nf_vld_reg   <= '0;
            end
            if (uc.op == OP_FILL_DONE) begin
                adm_reg <= adm_reg + AW'(1);
                fp_reg  <= (fp_inc >= (NW + 1)'(n)) ? '0 : SVW'(fp_inc);
            end
            if (head_we) begin
                head_vld_reg[head_wa] <= 1'b1;
            end
            if (uc.op == OP_FINISH) begin
                nf_vld_reg[srv_reg] <= 1'b1;
            end
            // Advance the scan pipeline flags
            if (uc.op == OP_SCAN_INIT) begin
                p1_vld_reg <= 1'b0;
                p2_vld_reg <= 1'b0;
            end else if (uc.op == OP_SCAN) begin
                p1_vld_reg <= scan_issue;
                p2_vld_reg <= p1_vld_reg;
            end
            // Result beat valid
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        unique case (uc.op)
            OP_TAKE: begin
                if (s_valid) begin
                    svc_reg <= s_service_minutes;
                    nd_reg  <= s_new_day;
                end
            end
            OP_FILL_INIT: begin
                srv_reg <= (NW'(fp_reg) >= n) ? '0 : fp_reg;
                rem_reg <= adm_reg;
                q_reg   <= '0;
                k_reg   <= KW'(LNW - 1);
            end
            OP_DIV_STEP: begin
                // One quotient bit of admitted / servers per step
                if (PW'(rem_reg) >= dsub) begin
                    rem_reg <= AW'(PW'(rem_reg) - dsub);
                    q_reg   <= q_reg | (LNW'(1) << k_reg);
                end
                if (k_reg != '0) begin
                    k_reg <= k_reg - KW'(1);
                end
            end
            OP_FILL_DONE: begin
                slot_reg <= q_reg;
            end
            OP_SCAN_INIT: begin
                j_reg     <= '0;
                early_reg <= TIME_MAX;
                best_reg  <= '0;
            end
            OP_SCAN: begin
                if (scan_issue) begin
                    j_reg <= j_reg + NW'(1);
                end
                p1_idx_reg <= j_reg[SVW-1:0];
                p2_idx_reg <= p1_idx_reg;
                // Keep the earliest head; lowest index wins a tie
                if (p2_vld_reg && line_rd_reg < early_reg) begin
                    early_reg <= line_rd_reg;
                    best_reg  <= p2_idx_reg;
                end
            end
            OP_HEAD_READ: begin
                srv_reg <= best_reg;
            end
            OP_HEAD_UPDATE: begin
                slot_reg <= h_eff;
            end
            OP_FINISH: begin
                start_reg <= start_val;
                end_reg   <= end_val;
            end
            OP_PRODUCT: begin
                prod_reg <= 32'(end_reg) * DIV60_MUL;
            end
            OP_OUT: begin
                if (out_load) begin
                    m_server_index    <= 5'(srv_reg);
                    m_start_minute    <= start_reg;
                    m_end_minute      <= end_reg;
                    m_end_hour        <= hour_val;
                    m_end_min_of_hour <= 6'(end_reg - hour_min);
                    m_refused         <= start_reg >= 16'(cfg.close_minute);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

@@ hdl/multi_line_job_dispatcher_core.sv @@
// Multi-line job dispatcher: each job beat carries a service time and gets
// a server, start and end minute (16-bit, saturating at 65535), end hour and
// minute of hour, and a refused flag when it starts at or after close_minute.
// The first window_count * line_capacity jobs of a day fill the lines round
// robin; later jobs go to the server whose head job ends earliest, lowest
// index on a tie. new_day clears the lines and restarts all servers at
// open_minute before its own job. A microcoded sequencer runs one job at a
// time: a fill-phase job works out its line slot with the one-bit-per-cycle
// slot divider; a full-phase job picks its server with the head scan, which
// reads one server line head per cycle through a three-stage memory
// pipeline. The result register takes a finished beat while the next job
// waits at the input. No clearing pass is needed after reset; the block is
// ready at once.
module multi_line_job_dispatcher_core
    import mljd_pkg::*;
#(
    parameter int MAX_SERVERS = 32,
    parameter int MAX_LINE    = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Job input
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [9:0]        s_service_minutes,
    input  logic              s_new_day,
    // Result output
    output logic              m_valid,
    input  logic              m_ready,
    output logic [4:0]        m_server_index,
    output logic [15:0]       m_start_minute,
    output logic [15:0]       m_end_minute,
    output logic [10:0]       m_end_hour,
    output logic [5:0]        m_end_min_of_hour,
    output logic              m_refused
);

    cfg_t    cfg;
    ucode_t  uc;
    status_t stat;

    // Configuration registers
    mljd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Control sequencer
    mljd_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .uc      (uc)
    );

    // Datapath
    mljd_dp #(
        .MAX_SERVERS (MAX_SERVERS),
        .MAX_LINE    (MAX_LINE)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .uc                (uc),
        .stat              (stat),
        .cfg               (cfg),
        .s_valid           (s_valid),
        .s_service_minutes (s_service_minutes),
        .s_new_day         (s_new_day),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_server_index    (m_server_index),
        .m_start_minute    (m_start_minute),
        .m_end_minute      (m_end_minute),
        .m_end_hour        (m_end_hour),
        .m_end_min_of_hour (m_end_min_of_hour),
        .m_refused         (m_refused)
    );

    // Take a job beat only in the idle step
    assign s_ready = (uc.op == OP_TAKE);

endmodule

@@ hdl/mljd_checker.sv @@
// Port-level checker for the job dispatcher, bound to the top level.
`include "multi_line_job_dispatcher_core_macros.svh"

module mljd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_start_minute,
    input logic [15:0] m_end_minute,
    input logic [10:0] m_end_hour,
    input logic [5:0]  m_end_min_of_hour
);

    // A stalled result beat holds
    `MLJD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_end_minute), "result beat dropped or changed while stalled")

    // A job never ends before it starts
    `MLJD_ASSERT_NOW(a_end_after_start, m_valid, m_end_minute >= m_start_minute, "end before start")

    // Hour and minute split recombine to the end minute
    `MLJD_ASSERT_NOW(a_hour_split, m_valid, (m_end_min_of_hour < 6'd60) && (27'(m_end_hour) * 27'd60 + 27'(m_end_min_of_hour) == 27'(m_end_minute)), "bad hour split")

    // One job at a time: no beat taken right after an accepted one
    `MLJD_ASSERT_NEXT(a_one_job, s_valid && s_ready, !s_ready, "input taken while a job is in work")

endmodule

bind multi_line_job_dispatcher_core mljd_checker u_mljd_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_start_minute    (m_start_minute),
    .m_end_minute      (m_end_minute),
    .m_end_hour        (m_end_hour),
    .m_end_min_of_hour (m_end_min_of_hour)
);

@@ tb/multi_line_job_dispatcher_core_test.sv @@
// Self-checking testbench of the multi-line job dispatcher core.
module multi_line_job_dispatcher_core_test;
    import mljd_pkg::*;

    localparam int SERVERS        = 32;
    localparam int LINE_DEPTH     = 16;
    localparam int JOB_TARGET     = 1150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 240;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct packed {
        logic [4:0]  server;
        logic [15:0] start_min;
        logic [15:0] end_min;
        logic [10:0] end_hr;
        logic [5:0]  end_mh;
        logic        refused;
    } job_result_t;

    logic              aclk;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    logic [9:0]        s_service_minutes;
    logic              s_new_day;
    logic              m_valid;
    logic              m_ready;
    logic [4:0]        m_server_index;
    logic [15:0]       m_start_minute;
    logic [15:0]       m_end_minute;
    logic [10:0]       m_end_hour;
    logic [5:0]        m_end_min_of_hour;
    logic              m_refused;

    multi_line_job_dispatcher_core DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_service_minutes (s_service_minutes),
        .s_new_day         (s_new_day),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_server_index    (m_server_index),
        .m_start_minute    (m_start_minute),
        .m_end_minute      (m_end_minute),
        .m_end_hour        (m_end_hour),
        .m_end_min_of_hour (m_end_min_of_hour),
        .m_refused         (m_refused)
    );

    // Shadow registers and dispatcher state
    logic [5:0]  win_count;
    logic [4:0]  line_cap;
    logic [10:0] open_min;
    logic [10:0] close_min;
    logic [15:0] free_at  [SERVERS];
    logic [15:0] slot_end [SERVERS*LINE_DEPTH];
    logic [3:0]  head     [SERVERS];
    int          admitted;
    int          fill_ptr;

    job_result_t expected_jobs[$];
    int          failures     = 0;
    int          sent_jobs    = 0;
    int          quiet_cycles = 0;
    bit          steady       = 1'b0;
    bit          hold_request = 1'b0;

    // Clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Restart every server at the opening minute and empty all lines
    function automatic void start_day();
        for (int i = 0; i < SERVERS; i++) begin
            free_at[i] = 16'(open_min);
            head[i]    = '0;
        end
        admitted = 0;
        fill_ptr = 0;
    endfunction

    // Place one job on a server and work out its times
    function automatic job_result_t schedule_job(input logic [9:0] svc, input logic nd);
        job_result_t r;
        int n, m, srv, slot, h, early, start_at, end_at;
        if (nd) start_day();
        n = (win_count == 0) ? 1 : ((win_count > SERVERS) ? SERVERS : int'(win_count));
        m = (line_cap == 0) ? 1 : ((line_cap > LINE_DEPTH) ? LINE_DEPTH : int'(line_cap));
        if (admitted < n * m) begin
            // fill phase: round robin over the servers
            if (fill_ptr >= n) fill_ptr = 0;
            srv = fill_ptr;
            slot = admitted / n;
            if (slot >= m) slot = 0;
            admitted++;
            fill_ptr = (fill_ptr + 1 >= n) ? 0 : fill_ptr + 1;
        end else begin
            // full phase: earliest head wins, lowest index on a tie
            srv = 0;
            early = 1 << 20;
            for (int j = 0; j < n; j++) begin
                h = head[j];
                if (h >= m) begin
                    h = 0;
                    head[j] = '0;
                end
                if (slot_end[j*LINE_DEPTH+h] < early) begin
                    early = slot_end[j*LINE_DEPTH+h];
                    srv = j;
                end
            end
            slot = head[srv];
            head[srv] = 4'((slot + 1 >= m) ? 0 : slot + 1);
        end
        start_at = free_at[srv];
        end_at = start_at + svc;
        if (end_at > TIME_MAX) end_at = TIME_MAX;
        free_at[srv] = 16'(end_at);
        slot_end[srv*LINE_DEPTH+slot] = 16'(end_at);
        r.server    = 5'(srv);
        r.start_min = 16'(start_at);
        r.end_min   = 16'(end_at);
        r.end_hr    = 11'(end_at / MIN_PER_HOUR);
        r.end_mh    = 6'(end_at % MIN_PER_HOUR);
        r.refused   = (start_at >= close_min);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Compare each result beat with the oldest pending job
    always @(posedge aclk) begin : result_check
        job_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_jobs.size() == 0) begin
                $error("result beat with no job pending");
                failures++;
            end else begin
                want = expected_jobs.pop_front();
                check_field("server_index", 16'(want.server), 16'(m_server_index));
                check_field("start_minute", want.start_min, m_start_minute);
                check_field("end_minute", want.end_min, m_end_minute);
                check_field("end_hour", 16'(want.end_hr), 16'(m_end_hour));
                check_field("end_min_of_hour", 16'(want.end_mh), 16'(m_end_min_of_hour));
                check_field("refused", 16'(want.refused), 16'(m_refused));
            end
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Result sink: random stall per beat, one long hold-off on request
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 13);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Offer one job beat and record its expected result once accepted
    task automatic send_job(input logic [9:0] svc, input logic nd);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_service_minutes <= svc;
        s_new_day         <= nd;
        do @(posedge aclk); while (!s_ready);
        expected_jobs.push_back(schedule_job(svc, nd));
        sent_jobs++;
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_jobs.size() != 0) @(posedge aclk);
    endtask

    // One APB write; psel stays up so writes can follow back to back
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        unique case (idx)
            REG_WINDOW_COUNT:  win_count = value[5:0];
            REG_LINE_CAPACITY: line_cap  = value[4:0];
            REG_OPEN_MINUTE:   open_min  = value[10:0];
            REG_CLOSE_MINUTE:  close_min = value[10:0];
        endcase
    endtask

    // Write all four registers, with random bits above each field
    task automatic configure(input int n, input int m, input int open_at, input int close_at);
        write_reg(REG_WINDOW_COUNT,  {26'($urandom), 6'(n)});
        write_reg(REG_LINE_CAPACITY, {27'($urandom), 5'(m)});
        write_reg(REG_OPEN_MINUTE,   {21'($urandom), 11'(open_at)});
        write_reg(REG_CLOSE_MINUTE,  {21'($urandom), 11'(close_at)});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reset geometry: zero and full service times, refusal at close
    task automatic test_reset_values();
        send_job(10'd0, 1'b1);
        send_job(10'd1023, 1'b0);
        send_job(10'd1023, 1'b0);
        drain_results();
    endtask

    // Zero server count and zero capacity act as one
    task automatic test_clamp_low();
        configure(0, 0, 480, 1020);
        send_job(10'd5, 1'b1);
        send_job(10'd7, 1'b0);
        drain_results();
    endtask

    // Round robin fill, then equal heads resolve to the lowest server
    task automatic test_fill_and_ties();
        logic [9:0] svc [8] = '{10'd10, 10'd10, 10'd10, 10'd300, 10'd5, 10'd5, 10'd0, 10'd20};
        configure(3, 2, 100, 400);
        for (int i = 0; i < 8; i++) send_job(svc[i], i == 0);
        drain_results();
    endtask

    // Shrink the geometry mid-day so heads wrap to zero
    task automatic test_geometry_shrink();
        configure(2, 1, 100, 400);
        send_job(10'd40, 1'b0);
        send_job(10'd3, 1'b0);
        drain_results();
    endtask

    // New opening minute waits for the next day; extreme open and close
    task automatic test_open_change();
        configure(2, 1, 0, 0);
        send_job(10'd3, 1'b0);
        send_job(10'd1023, 1'b1);
        drain_results();
        configure(1, 1, 2047, 2047);
        send_job(10'd1, 1'b1);
        send_job(10'd0, 1'b0);
        drain_results();
    endtask

    // Hold off the sink while jobs keep coming so the input stalls
    task automatic test_backpressure();
        configure(2, 2, 480, 1020);
        steady = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 16; i++) send_job(10'($urandom_range(0, 1023)), i == 0);
        steady = 1'b0;
        drain_results();
    endtask

    // One server with long jobs runs into the 65535 ceiling
    task automatic test_saturation();
        configure(1, 1, 2047, 0);
        for (int i = 0; i < 72; i++) send_job(10'($urandom_range(960, 1023)), i == 0);
        drain_results();
    endtask

    // Out-of-range geometry clamps to every server and every slot
    task automatic test_full_geometry();
        configure(63, 31, $urandom_range(0, 2047), $urandom_range(0, 2047));
        for (int i = 0; i < SERVERS * LINE_DEPTH + 24; i++) begin
            send_job(10'($urandom_range(0, 1023)), i == 0);
        end
        drain_results();
    endtask

    // Random settings per day, random jobs, occasional extra new days
    task automatic test_random_days();
        int n, m, n_eff, m_eff, count, pick, open_at, close_at;
        bit tie_heavy;
        logic [9:0] svc;
        while (sent_jobs < JOB_TARGET) begin
            pick = $urandom_range(0, 9);
            n = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(33, 63) :
                (pick == 2) ? 32 : $urandom_range(1, 6);
            n_eff = (n == 0) ? 1 : ((n > SERVERS) ? SERVERS : n);
            pick = $urandom_range(0, 9);
            if (n_eff > 8) begin
                m = $urandom_range(0, 2);
            end else begin
                m = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(17, 31) :
                    (pick == 2) ? 16 : $urandom_range(1, 4);
            end
            if (m >= LINE_DEPTH && n_eff > 3) n = $urandom_range(1, 3);
            n_eff = (n == 0) ? 1 : ((n > SERVERS) ? SERVERS : n);
            m_eff = (m == 0) ? 1 : ((m > LINE_DEPTH) ? LINE_DEPTH : m);
            open_at = $urandom_range(0, 2047);
            close_at = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2047) :
                       ((open_at + $urandom_range(0, 600)) % 2048);
            configure(n, m, open_at, close_at);
            tie_heavy = ($urandom_range(0, 3) == 0);
            steady = ($urandom_range(0, 3) == 0);
            count = n_eff * m_eff + $urandom_range(8, 40);
            for (int i = 0; i < count; i++) begin
                svc = tie_heavy ? 10'($urandom_range(0, 3)) : 10'($urandom_range(0, 1023));
                send_job(svc, (i == 0) || ($urandom_range(0, 29) == 0));
            end
            drain_results();
            steady = 1'b0;
        end
    endtask

    initial begin : run
        aresetn           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        s_valid           <= 1'b0;
        s_service_minutes <= '0;
        s_new_day         <= 1'b0;
        win_count = RESET_WINDOW_COUNT;
        line_cap  = RESET_LINE_CAPACITY;
        open_min  = RESET_OPEN;
        close_min = RESET_CLOSE;
        for (int i = 0; i < SERVERS * LINE_DEPTH; i++) slot_end[i] = '0;
        start_day();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_clamp_low();
        test_fill_and_ties();
        test_geometry_shrink();
        test_open_change();
        test_backpressure();
        test_saturation();
        test_full_geometry();
        test_random_days();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
